FILE: design/lsef_pkg.sv
package lsef_pkg;

    // width of the stream byte counter
    localparam int POSITION_WIDTH = 24;
    localparam int PIXELS_WIDTH   = 25;
    localparam int LENGTH_WIDTH   = 32;

    // largest stream position, carried one bit wider than any length
    localparam logic [LENGTH_WIDTH:0] POS_MAX =
        (33'd1 << POSITION_WIDTH) - 33'd1;

    localparam logic [LENGTH_WIDTH-1:0] LEN_MIN     = 32'd38;
    localparam logic [LENGTH_WIDTH-1:0] ENC_LEN_MIN = 32'd70;

    localparam logic [7:0] FRAME_MAGIC [4] = '{8'h46, 8'h47, 8'h53, 8'h54};

    // byte queue between the bit gatherer and the frame parser
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // result status codes
    localparam logic [1:0] ST_DATA      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN   = 2'd1;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
    localparam logic [1:0] ST_ENC_SHORT = 2'd3;

    // region tags
    localparam logic [2:0] RG_VERSION = 3'd0;
    localparam logic [2:0] RG_FLAGS   = 3'd1;
    localparam logic [2:0] RG_SALT    = 3'd2;
    localparam logic [2:0] RG_IV      = 3'd3;
    localparam logic [2:0] RG_DIGEST  = 3'd4;
    localparam logic [2:0] RG_PAYLOAD = 3'd5;

    // one assembled stream byte, first marks the first byte after a restart
    typedef struct packed {
        logic       first;
        logic [7:0] data;
    } t_byte_req;

endpackage

FILE: design/lsef_front.sv
module lsef_front
    import lsef_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic      i_first_pixel,
    input  logic      i_red_lsb,
    input  logic      i_green_lsb,
    input  logic      i_blue_lsb,
    input  logic      i_q_ready,
    output logic      o_push,
    output t_byte_req o_push_req
);

    logic       r_run, n_run;
    logic [2:0] r_count, n_count;
    logic [7:0] r_shift, n_shift;
    logic       r_pend_first, n_pend_first;

    logic        accept;
    logic        run_eff;
    logic [2:0]  count_eff;
    logic [7:0]  shift_eff;
    logic [10:0] tmp;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid & i_q_ready;
    assign run_eff    = i_first_pixel | r_run;
    assign count_eff  = i_first_pixel ? 3'd0 : r_count;
    assign shift_eff  = i_first_pixel ? 8'd0 : r_shift;
    assign tmp        = {shift_eff, i_red_lsb, i_green_lsb, i_blue_lsb};

    always_comb begin
        n_run           = r_run;
        n_count         = r_count;
        n_shift         = r_shift;
        n_pend_first    = r_pend_first;
        o_push          = 1'b0;
        o_push_req.first = r_pend_first;
        o_push_req.data  = tmp[7:0];
        if (accept && run_eff) begin
            n_run = 1'b1;
            if (i_first_pixel) begin
                n_pend_first = 1'b1;
            end
            // at most one byte completes per pixel
            unique case (count_eff)
                3'd5: begin
                    o_push          = 1'b1;
                    o_push_req.data = tmp[7:0];
                    n_shift         = 8'd0;
                    n_count         = 3'd0;
                end
                3'd6: begin
                    o_push          = 1'b1;
                    o_push_req.data = tmp[8:1];
                    n_shift         = {7'd0, tmp[0]};
                    n_count         = 3'd1;
                end
                3'd7: begin
                    o_push          = 1'b1;
                    o_push_req.data = tmp[9:2];
                    n_shift         = {6'd0, tmp[1:0]};
                    n_count         = 3'd2;
                end
                default: begin
                    n_shift = tmp[7:0];
                    n_count = count_eff + 3'd3;
                end
            endcase
            if (o_push) begin
                n_pend_first = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= 1'b0;
            r_count      <= 3'd0;
            r_shift      <= 8'd0;
            r_pend_first <= 1'b0;
        end else begin
            r_run        <= n_run;
            r_count      <= n_count;
            r_shift      <= n_shift;
            r_pend_first <= n_pend_first;
        end
    end

endmodule

FILE: design/lsef_queue.sv
module lsef_queue
    import lsef_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_byte_req i_push_req,
    output logic      o_ready,
    input  logic      i_pop,
    output logic      o_valid,
    output t_byte_req o_head
);

    t_byte_req r_mem [QUEUE_DEPTH];

    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QUEUE_AW:0]   r_cnt, n_cnt;
    logic                do_push, do_pop;

    assign o_ready = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("byte pushed into a full queue");

endmodule

FILE: design/lsef_back.sv
module lsef_back
    import lsef_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [PIXELS_WIDTH-1:0] i_image_pixels,
    input  logic                    i_q_valid,
    input  t_byte_req               i_q_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [7:0]              o_data_byte,
    output logic [2:0]              o_region,
    output logic [1:0]              o_status,
    output logic                    o_encrypted,
    output logic                    o_last
);

    logic                      r_run, n_run;
    logic [POSITION_WIDTH-1:0] r_pos, n_pos;
    logic [LENGTH_WIDTH-1:0]   r_len, n_len;
    logic                      r_enc, n_enc;

    logic       r_out_valid;
    logic [7:0] r_data;
    logic [2:0] r_region;
    logic [1:0] r_status;
    logic       r_encrypted;
    logic       r_last;

    logic                      run_eff, enc_eff;
    logic [POSITION_WIDTH-1:0] pos_eff;
    logic [LENGTH_WIDTH-1:0]   len_eff, len_new;
    logic [7:0]                b;
    logic                      len_bad;
    logic [35:0]               need_bits;
    logic [35:0]               have_bits;
    logic                      emit;
    logic [7:0]                e_data;
    logic [2:0]                e_region;
    logic [1:0]                e_status;
    logic                      e_last;

    assign o_pop   = i_q_valid & (!r_out_valid | i_out_ready);
    assign b       = i_q_head.data;
    assign run_eff = i_q_head.first | r_run;
    assign pos_eff = i_q_head.first ? '0 : r_pos;
    assign len_eff = i_q_head.first ? '0 : r_len;
    assign enc_eff = i_q_head.first ? 1'b0 : r_enc;
    assign len_new = {len_eff[LENGTH_WIDTH-9:0], b};

    // capacity check: (4 + length) * 8 against three bits per pixel
    assign need_bits = {1'b0, len_new, 3'b000} + 36'd32;
    assign have_bits = 36'(i_image_pixels) + {10'd0, i_image_pixels, 1'b0};
    assign len_bad   = (len_new < LEN_MIN) || (need_bits > have_bits)
                       || ({1'b0, len_new} + 33'd3 > POS_MAX);

    always_comb begin
        n_run    = r_run;
        n_pos    = r_pos;
        n_len    = r_len;
        n_enc    = r_enc;
        emit     = 1'b0;
        e_data   = 8'd0;
        e_region = RG_VERSION;
        e_status = ST_DATA;
        e_last   = 1'b0;
        if (o_pop && run_eff) begin
            n_run = 1'b1;
            n_pos = pos_eff + 1'b1;
            n_len = len_eff;
            n_enc = enc_eff;
            priority if (pos_eff < POSITION_WIDTH'(4)) begin
                n_len = len_new;
                if (pos_eff == POSITION_WIDTH'(3) && len_bad) begin
                    emit     = 1'b1;
                    e_status = ST_BAD_LEN;
                    e_last   = 1'b1;
                end
            end else if (pos_eff < POSITION_WIDTH'(8)) begin
                if (b != FRAME_MAGIC[pos_eff[1:0]]) begin
                    emit     = 1'b1;
                    e_status = ST_BAD_MAGIC;
                    e_last   = 1'b1;
                end
            end else if (pos_eff == POSITION_WIDTH'(8)) begin
                emit     = 1'b1;
                e_data   = b;
                e_region = RG_VERSION;
            end else if (pos_eff == POSITION_WIDTH'(9)) begin
                n_enc = b[0];
                emit  = 1'b1;
                if (b[0] && len_eff < ENC_LEN_MIN) begin
                    e_status = ST_ENC_SHORT;
                    e_last   = 1'b1;
                end else begin
                    e_data   = b;
                    e_region = RG_FLAGS;
                end
            end else begin
                emit   = 1'b1;
                e_data = b;
                e_last = ({1'b0, len_eff} + 33'd3) == 33'(pos_eff);
                priority if (enc_eff && pos_eff < POSITION_WIDTH'(26)) begin
                    e_region = RG_SALT;
                end else if (enc_eff && pos_eff < POSITION_WIDTH'(42)) begin
                    e_region = RG_IV;
                end else if (enc_eff && pos_eff < POSITION_WIDTH'(74)) begin
                    e_region = RG_DIGEST;
                end else if (!enc_eff && pos_eff < POSITION_WIDTH'(42)) begin
                    e_region = RG_DIGEST;
                end else begin
                    e_region = RG_PAYLOAD;
                end
            end
            if (e_last) begin
                n_run = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_pos       <= '0;
            r_len       <= '0;
            r_enc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_run <= n_run;
            r_pos <= n_pos;
            r_len <= n_len;
            r_enc <= n_enc;
            if (o_pop) begin
                r_out_valid <= emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_data      <= e_data;
            r_region    <= e_region;
            r_status    <= e_status;
            r_encrypted <= n_enc;
            r_last      <= e_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_data;
    assign o_region    = r_region;
    assign o_status    = r_status;
    assign o_encrypted = r_encrypted;
    assign o_last      = r_last;

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_DATA) |-> r_last)
        else $error("error result without last");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_DATA) |-> (r_data == 8'd0 && r_region == RG_VERSION))
        else $error("error result carries data");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && emit && e_last) |=> !r_run)
        else $error("parser still running after last result");

endmodule

FILE: design/lsb_stego_frame_extractor.sv
// lsb steganography frame extractor: takes one rgb pixel per request, gathers the
// least significant bit of red, green and blue (msb first) into stream bytes, and
// parses the frame that follows a 32-bit big-endian length. a pixel with
// i_first_pixel high restarts extraction and supplies the first three bits.
// the length is rejected (status 1) if below 38, if the frame needs more than
// three bits per pixel of i_cfg_image_pixels, or if length + 3 passes the 24-bit
// position range; a wrong "FGST" magic gives status 2, an encrypted flags byte
// with length below 70 gives status 3. version, flags, salt, iv, digest and
// payload bytes come out tagged by region, the final one with o_last; after
// o_last or any error, pixels are ignored until the next first pixel. at most
// one result per pixel. throughput is one pixel per clock: the bit gatherer
// takes a pixel every cycle and hands finished bytes through a 4-entry queue to
// the frame parser, which handles one byte per cycle into a registered output,
// so a stalled output only stops input once the queue has filled. the byte a
// pixel completes goes into the queue and then into the result register, later
// while earlier bytes still wait in the queue. write i_cfg_image_pixels only
// while the block is idle; it resets to 0.
module lsb_stego_frame_extractor
    import lsef_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [PIXELS_WIDTH-1:0] i_cfg_image_pixels,
    // pixel requests
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_first_pixel,
    input  logic [7:0]              i_red,
    input  logic [7:0]              i_green,
    input  logic [7:0]              i_blue,
    // result requests
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [7:0]              o_data_byte,
    output logic [2:0]              o_region,
    output logic [1:0]              o_status,
    output logic                    o_encrypted,
    output logic                    o_last
);

    logic [PIXELS_WIDTH-1:0] r_image_pixels;

    logic      push;
    t_byte_req push_req;
    logic      q_ready;
    logic      q_valid;
    logic      pop;
    t_byte_req q_head;

    // capacity register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_pixels <= '0;
        end else if (i_cfg_valid) begin
            r_image_pixels <= i_cfg_image_pixels;
        end
    end

    // front: bit gathering into bytes
    lsef_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_first_pixel (i_first_pixel),
        .i_red_lsb     (i_red[0]),
        .i_green_lsb   (i_green[0]),
        .i_blue_lsb    (i_blue[0]),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_push_req    (push_req)
    );

    // decoupling queue of stream bytes
    lsef_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_req (push_req),
        .o_ready    (q_ready),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    // back: frame parsing and result register
    lsef_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_image_pixels (r_image_pixels),
        .i_q_valid      (q_valid),
        .i_q_head       (q_head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_data_byte    (o_data_byte),
        .o_region       (o_region),
        .o_status       (o_status),
        .o_encrypted    (o_encrypted),
        .o_last         (o_last)
    );

endmodule

FILE: test/tb_lsb_stego_frame_extractor.sv
`timescale 1ns / 100ps

module tb_lsb_stego_frame_extractor;
    import lsef_pkg::*;

    // cycles without any accepted request before the run is abandoned
    localparam int QUIET_LIMIT = 4000;
    // long receiver hold-off, long enough to fill the internal byte queue
    localparam int HOLD_CYCLES = 400;
    localparam int PIXEL_TARGET = 1550;

    // pixel request and one frame result
    typedef struct packed {
        logic       first;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] region;
        logic [1:0] status;
        logic       enc;
        logic       last;
    } t_frame_out;

    // extraction phase of the local predictor
    typedef enum logic [1:0] {
        EX_IDLE,
        EX_RUN,
        EX_DONE
    } t_ex_state;

    // kinds of embedded stream the stimulus builds
    typedef enum logic [2:0] {
        FK_GOOD,
        FK_SHORT_LEN,
        FK_HUGE_LEN,
        FK_BAD_MAGIC,
        FK_ENC_SHORT,
        FK_CUT,
        FK_NOISE
    } t_frame_kind;

    logic                    i_clk              = 1'b0;
    logic                    i_rst_n            = 1'b0;
    logic                    i_cfg_valid        = 1'b0;
    logic                    o_cfg_ready;
    logic [PIXELS_WIDTH-1:0] i_cfg_image_pixels = '0;
    logic                    i_in_valid         = 1'b0;
    logic                    o_in_ready;
    logic                    i_first_pixel      = 1'b0;
    logic [7:0]              i_red              = 8'h00;
    logic [7:0]              i_green            = 8'h00;
    logic [7:0]              i_blue             = 8'h00;
    logic                    o_out_valid;
    logic                    i_out_ready        = 1'b0;
    logic [7:0]              o_data_byte;
    logic [2:0]              o_region;
    logic [1:0]              o_status;
    logic                    o_encrypted;
    logic                    o_last;

    lsb_stego_frame_extractor DUT (.*);

    always #2 i_clk = ~i_clk;

    // pixels waiting to be offered, results still to come
    t_pixel     pixel_q[$];
    t_frame_out extracted_q[$];
    // stream bytes of the frame under construction
    logic [7:0] frame_bytes[$];

    // predictor state, mirrors the block's architectural state
    logic [PIXELS_WIDTH-1:0]   cap_pixels = '0;
    logic [7:0]                sh_byte    = 8'h00;
    logic [2:0]                sh_cnt     = 3'd0;
    logic [POSITION_WIDTH-1:0] byte_pos   = '0;
    logic [LENGTH_WIDTH-1:0]   frm_len    = '0;
    logic                      enc_flag   = 1'b0;
    t_ex_state                 ex_state   = EX_IDLE;

    // run bookkeeping
    int fail_cnt       = 0;
    int pixels_queued  = 0;
    int pixels_taken   = 0;
    int results_seen   = 0;
    int errors_seen    = 0;
    int lasts_seen     = 0;
    int cfg_writes     = 0;
    int quiet_cycles   = 0;

    // sender and receiver pacing, each owned by its own process
    t_pixel cur_px;
    int     send_wait  = 0;
    bit     send_burst = 1'b0;
    int     rdy_wait   = 0;
    int     hold_left  = 0;
    bit     rdy_burst  = 1'b0;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // queue one result, a last result ends extraction until the next restart
    task automatic emit(input logic [7:0] data, input logic [2:0] region,
                        input logic [1:0] status, input logic last);
        t_frame_out r;
        r.data   = data;
        r.region = region;
        r.status = status;
        r.enc    = enc_flag;
        r.last   = last;
        extracted_q.push_back(r);
        if (last) begin
            ex_state = EX_DONE;
        end
    endtask

    // parse one assembled stream byte at the current stream position
    task automatic parse_byte(input logic [7:0] b);
        logic [POSITION_WIDTH-1:0] pos;
        logic [63:0]               len64;
        logic [63:0]               cap64;
        logic [63:0]               off;
        logic [2:0]                region;
        pos      = byte_pos;
        byte_pos = byte_pos + 1'b1;
        if (pos < 4) begin
            // big-endian frame length
            frm_len = {frm_len[LENGTH_WIDTH-9:0], b};
            if (pos == 3) begin
                len64 = frm_len;
                cap64 = cap_pixels;
                // too short, beyond three bits per pixel, or past the position counter
                if (frm_len < LEN_MIN || (len64 + 4) * 8 > cap64 * 3
                        || len64 + 3 > POS_MAX) begin
                    emit(8'h00, RG_VERSION, ST_BAD_LEN, 1'b1);
                end
            end
        end else if (pos < 8) begin
            // magic bytes, first mismatch stops at once
            if (b != FRAME_MAGIC[pos[1:0]]) begin
                emit(8'h00, RG_VERSION, ST_BAD_MAGIC, 1'b1);
            end
        end else if (pos == 8) begin
            emit(b, RG_VERSION, ST_DATA, 1'b0);
        end else if (pos == 9) begin
            enc_flag = b[0];
            // encrypted frame must hold salt, iv and digest
            if (enc_flag && frm_len < ENC_LEN_MIN) begin
                emit(8'h00, RG_VERSION, ST_ENC_SHORT, 1'b1);
            end else begin
                emit(b, RG_FLAGS, ST_DATA, 1'b0);
            end
        end else begin
            off   = pos - 4;
            len64 = frm_len;
            if (enc_flag) begin
                region = off < 22 ? RG_SALT : off < 38 ? RG_IV
                       : off < 70 ? RG_DIGEST : RG_PAYLOAD;
            end else begin
                region = off < 38 ? RG_DIGEST : RG_PAYLOAD;
            end
            // last frame byte, the digest's last when the payload is empty
            emit(b, region, ST_DATA, (64'(pos) == len64 + 3) ? 1'b1 : 1'b0);
        end
    endtask

    // one accepted pixel: restart if asked, then shift in red, green, blue lsbs
    task automatic extract_pixel(input t_pixel px);
        logic [2:0] lsbs;
        int         i;
        if (px.first) begin
            sh_byte  = 8'h00;
            sh_cnt   = 3'd0;
            byte_pos = '0;
            frm_len  = '0;
            enc_flag = 1'b0;
            ex_state = EX_RUN;
        end
        lsbs = {px.red[0], px.green[0], px.blue[0]};
        for (i = 2; i >= 0; i--) begin
            // bits left in the pixel after an error or the last byte are dropped
            if (ex_state == EX_RUN) begin
                sh_byte = {sh_byte[6:0], lsbs[i]};
                if (sh_cnt == 3'd7) begin
                    sh_cnt = 3'd0;
                    parse_byte(sh_byte);
                    sh_byte = 8'h00;
                end else begin
                    sh_cnt = sh_cnt + 1'b1;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus builders
    // ---------------------------------------------------------------

    // stream bit k, msb first, random past the end of the stream
    function automatic logic stream_bit(input int k, input int nbits);
        if (k >= nbits) begin
            return logic'($urandom_range(0, 1));
        end
        return frame_bytes[k / 8][7 - (k % 8)];
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // length, magic (one byte spoiled when bad_idx < 4), version, flags, body
    task automatic make_frame(input logic [31:0] len, input logic [7:0] flags,
                              input int bad_idx);
        int         k;
        int         body;
        logic [7:0] flip;
        frame_bytes.delete();
        for (k = 3; k >= 0; k--) begin
            frame_bytes.push_back(len[8*k +: 8]);
        end
        for (k = 0; k < 4; k++) begin
            flip = (k == bad_idx) ? 8'($urandom_range(1, 255)) : 8'h00;
            frame_bytes.push_back(FRAME_MAGIC[k] ^ flip);
        end
        frame_bytes.push_back(rand_byte());
        frame_bytes.push_back(flags);
        body = (len > 6 && len < 256) ? int'(len) - 6 : 8;
        for (k = 0; k < body; k++) begin
            frame_bytes.push_back(rand_byte());
        end
    endtask

    // turn the first nbytes stream bytes into pixel requests, upper bits random
    task automatic send_stream(input int nbytes);
        int     k;
        int     nbits;
        t_pixel px;
        nbits = nbytes * 8;
        for (k = 0; k < nbits; k += 3) begin
            px.first = (k == 0);
            px.red   = {7'($urandom_range(0, 127)), stream_bit(k, nbits)};
            px.green = {7'($urandom_range(0, 127)), stream_bit(k + 1, nbits)};
            px.blue  = {7'($urandom_range(0, 127)), stream_bit(k + 2, nbits)};
            pixel_q.push_back(px);
            pixels_queued++;
        end
    endtask

    // fully random pixels, a restart now and then
    task automatic send_noise(input int n);
        int     k;
        t_pixel px;
        for (k = 0; k < n; k++) begin
            px.first = ($urandom_range(0, 15) == 0);
            px.red   = rand_byte();
            px.green = rand_byte();
            px.blue  = rand_byte();
            pixel_q.push_back(px);
            pixels_queued++;
        end
    endtask

    task automatic queue_frame(input t_frame_kind kind);
        logic [31:0] len;
        logic [7:0]  flags;
        int          bad_idx;
        flags = rand_byte();
        case (kind)
            FK_GOOD, FK_CUT: begin
                if ($urandom_range(0, 1) == 1) begin
                    // encrypted, sometimes with an empty payload
                    flags[0] = 1'b1;
                    len = ($urandom_range(0, 7) == 0) ? ENC_LEN_MIN
                        : 32'($urandom_range(70, 110));
                end else begin
                    flags[0] = 1'b0;
                    len = ($urandom_range(0, 7) == 0) ? LEN_MIN
                        : 32'($urandom_range(38, 80));
                end
                make_frame(len, flags, 4);
                // a cut frame is abandoned by the restart of the next one
                send_stream(kind == FK_CUT ? $urandom_range(1, frame_bytes.size() - 1)
                                           : frame_bytes.size());
            end
            FK_SHORT_LEN: begin
                make_frame(32'($urandom_range(0, 37)), flags, 4);
                send_stream($urandom_range(4, 8));
            end
            FK_HUGE_LEN: begin
                len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                    : (32'($urandom) | 32'h0080_0000);
                make_frame(len, flags, 4);
                send_stream($urandom_range(4, 8));
            end
            FK_BAD_MAGIC: begin
                bad_idx = $urandom_range(0, 3);
                make_frame(32'($urandom_range(38, 80)), flags, bad_idx);
                send_stream(5 + bad_idx + $urandom_range(0, 2));
            end
            FK_ENC_SHORT: begin
                flags[0] = 1'b1;
                make_frame(32'($urandom_range(38, 69)), flags, 4);
                send_stream($urandom_range(10, 13));
            end
            default: begin
                send_noise($urandom_range(1, 12));
            end
        endcase
    endtask

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)  return FK_GOOD;
        if (r < 10) return FK_SHORT_LEN;
        if (r < 11) return FK_HUGE_LEN;
        if (r < 13) return FK_BAD_MAGIC;
        if (r < 15) return FK_ENC_SHORT;
        if (r < 18) return FK_CUT;
        return FK_NOISE;
    endfunction

    // ---------------------------------------------------------------
    // configuration and phase control
    // ---------------------------------------------------------------

    task automatic write_capacity(input logic [PIXELS_WIDTH-1:0] value);
        @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_image_pixels <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_pixels = value;
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // all pixels taken, all results back, then let the pipeline drain
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || i_in_valid || extracted_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        t_pixel px;
        int     ph;
        int     nfr;
        int     k;
        int     blen;
        int     bpix;
        logic [7:0] flags;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: pixels ignored before any restart, all-zero and all-one
        px = '{first: 1'b0, red: 8'h00, green: 8'h00, blue: 8'h00};
        pixel_q.push_back(px);
        px = '{first: 1'b0, red: 8'hFF, green: 8'hFF, blue: 8'hFF};
        pixel_q.push_back(px);
        // zero length under the reset capacity, then a pixel ignored once done
        make_frame(32'd0, 8'h00, 4);
        send_stream(4);
        pixel_q.push_back(px);
        pixels_queued += 3;
        wait_idle();

        ph = 0;
        while (pixels_queued < PIXEL_TARGET) begin
            nfr = $urandom_range(2, 5);
            blen = 0;
            // capacity setting for this phase, extremes first
            case (ph == 0 ? 0 : ph == 1 ? 1 : ph == 2 ? 3 : $urandom_range(0, 5))
                0: write_capacity('0);
                1: write_capacity(25'h100_0000);
                2: write_capacity(25'($urandom_range(0, 25'h100_0000)));
                3: begin
                    // capacity that fits a frame exactly, one byte more fails
                    blen = $urandom_range(38, 90);
                    bpix = ((4 + blen) * 8 + 2) / 3;
                    write_capacity(25'(bpix));
                end
                4: write_capacity(25'($urandom_range(200, 600)));
                default: write_capacity(25'($urandom_range(2000, 25'h100_0000)));
            endcase
            if (blen != 0) begin
                flags = rand_byte();
                flags[0] = (blen >= ENC_LEN_MIN) ? flags[0] : 1'b0;
                make_frame(32'(blen), flags, 4);
                send_stream(frame_bytes.size());
                make_frame(32'(blen + 1), flags, 4);
                send_stream(6);
            end
            for (k = 0; k < nfr; k++) begin
                queue_frame(pick_kind());
            end
            // close the phase on a rejected length so the block ends up done
            queue_frame(FK_SHORT_LEN);
            wait_idle();
            ph++;
        end

        repeat (10) @(negedge i_clk);
        if (extracted_q.size() != 0) begin
            $error("%0d results never arrived", extracted_q.size());
            fail_cnt++;
        end
        $display("covered %0d pixels over %0d capacity settings, %0d results checked",
                 pixels_taken, cfg_writes, results_seen);
        $display("of which %0d error results and %0d frame ends", errors_seen, lasts_seen);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // pixel driver: offers queued pixels, predicts on acceptance
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                extract_pixel(cur_px);
                pixels_taken++;
                send_wait = send_burst ? 0 : $urandom_range(0, 9);
                // switch between paced and back-to-back stretches
                if (pixels_taken % 100 == 0) begin
                    send_burst = ($urandom_range(0, 3) == 0);
                end
            end
            // request slot free: either nothing offered or just taken
            if (!i_in_valid || o_in_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    cur_px = pixel_q.pop_front();
                    i_first_pixel <= cur_px.first;
                    i_red         <= cur_px.red;
                    i_green       <= cur_px.green;
                    i_blue        <= cur_px.blue;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor and receiver pacing
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (extracted_q.size() == 0) begin
                    $error("result with nothing pending: data_byte %0h status %0d",
                           o_data_byte, o_status);
                    fail_cnt++;
                end else begin
                    want = extracted_q.pop_front();
                    check_field("data_byte", want.data, o_data_byte);
                    check_field("region", 8'(want.region), 8'(o_region));
                    check_field("status", 8'(want.status), 8'(o_status));
                    check_field("encrypted", 8'(want.enc), 8'(o_encrypted));
                    check_field("last", 8'(want.last), 8'(o_last));
                end
                results_seen++;
                errors_seen += (o_status != ST_DATA);
                lasts_seen  += o_last;
                rdy_wait = rdy_burst ? 0 : $urandom_range(0, 9);
                if (results_seen % 64 == 0) begin
                    rdy_burst = ($urandom_range(0, 2) == 0);
                end
                // long hold-off so the byte queue fills and input stalls
                if (results_seen == 120 || results_seen == 700) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (rdy_wait > 0) begin
                rdy_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: any accepted request on any channel resets the count
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no request accepted for %0d cycles, %0d results pending",
                   QUIET_LIMIT, extracted_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

FILE: filelist.f
design/lsef_pkg.sv
design/lsef_front.sv
design/lsef_queue.sv
design/lsef_back.sv
design/lsb_stego_frame_extractor.sv
test/tb_lsb_stego_frame_extractor.sv
